@@ rtl/png_enc_pkg.sv @@
// Shared constants, byte tables, command and status types for the PNG stream encoder.
package png_enc_pkg;

  localparam int unsigned MAX_BLOCK_BYTES_DEF = 65535;
  localparam int unsigned DIV_W               = 16;
  localparam int unsigned IDX_W               = 6;

  localparam logic [IDX_W-1:0] HDR_LEN        = 6'd33;
  localparam logic [IDX_W-1:0] OPEN_LEN_FIRST = 6'd15;
  localparam logic [IDX_W-1:0] OPEN_LEN       = 6'd13;
  localparam logic [IDX_W-1:0] CRC_LEN        = 6'd4;
  localparam logic [IDX_W-1:0] TRAIL_LEN      = 6'd20;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  localparam logic [7:0] PNG_SIG [8] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
  };
  localparam logic [7:0] IEND_BYTES [12] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h49, 8'h45, 8'h4E, 8'h44,
    8'hAE, 8'h42, 8'h60, 8'h82
  };

  typedef enum logic [2:0] {
    SEL_HDR,
    SEL_OPEN,
    SEL_FILT,
    SEL_SAMP,
    SEL_CRC,
    SEL_TRAIL
  } byte_sel_t;

  typedef struct packed {
    logic             emit;
    byte_sel_t        sel;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             fend;
    logic             take;
    logic             latch;
    logic             rowb;
    logic             div_start;
    logic             set_rpc;
    logic             open_a;
    logic             open_b;
    logic             open_done;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
    logic rpos_zero;
    logic ric_zero;
    logic row_end;
    logic chunk_end;
    logic chunk_last;
    logic first;
  } dp_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

endpackage

@@ rtl/png_enc_div.sv @@
// Restoring divider, one quotient bit per cycle.
module png_enc_div
  import png_enc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W:0]   divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   rem;
  logic [DIV_W+1:0] trial;
  logic             ge;

  assign trial = {rem, quotient[DIV_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? (DIV_W+1)'(trial - {1'b0, divisor}) : trial[DIV_W:0];
      quotient <= {quotient[DIV_W-2:0], ge};
    end
  end

endmodule

@@ rtl/png_enc_dp.sv @@
// Datapath: configuration, image counters, CRC-32, Adler-32, byte select and output register.
module png_enc_dp
  import png_enc_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic [7:0]  sample_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        file_end
);

  localparam logic [15:0] MAXW_GREY = 16'(MAX_BLOCK_BYTES - 1);
  localparam logic [15:0] MAXW_RGB  = 16'((MAX_BLOCK_BYTES - 1) / 3);
  localparam logic [15:0] BLK_BYTES = 16'(MAX_BLOCK_BYTES);

  logic [15:0] cfg_width;
  logic [30:0] cfg_height;
  logic        cfg_mode;

  logic [7:0]  samp;
  logic [15:0] lat_width;
  logic [30:0] lat_height;
  logic        rgb;
  logic [16:0] row_bytes;
  logic [15:0] rows_per_chunk;
  logic [30:0] rows_done;
  logic [16:0] row_byte_position;
  logic [15:0] rows_in_chunk;
  logic [15:0] chunk_rows;
  logic        chunk_last;
  logic        first_chunk_flag;
  logic [15:0] len;
  logic [31:0] chunk_crc;
  logic [15:0] adler_low_sum;
  logic [15:0] adler_high_sum;

  logic        div_busy;
  logic [15:0] quotient;

  logic [15:0] w_in;
  logic [15:0] maxw;
  logic [30:0] left;
  logic [31:0] dlen;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] off;
  logic [7:0]  b;
  logic        crc_en;
  logic        crc_init;
  logic        adl_en;
  logic [31:0] crc_src;
  logic [16:0] low_sum;
  logic [16:0] low_next;
  logic [16:0] high_sum;
  logic [16:0] high_next;
  logic [32:0] len_prod;

  png_enc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (BLK_BYTES),
    .divisor  (row_bytes),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= 16'd1;
      cfg_height <= 31'd1;
      cfg_mode   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:  cfg_width  <= cfg_data[15:0];
        REG_HEIGHT: cfg_height <= cfg_data;
        REG_MODE:   cfg_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign w_in     = (cfg_width == 16'd0) ? 16'd1 : cfg_width;
  assign maxw     = cfg_mode ? MAXW_RGB : MAXW_GREY;
  assign left     = lat_height - rows_done;
  assign len_prod = 33'(chunk_rows) * 33'(row_bytes);
  assign dlen     = 32'(len) + 32'd5 + (first_chunk_flag ? 32'd2 : 32'd0)
                  + (chunk_last ? 32'd4 : 32'd0);

  // Byte select for the current command
  always_comb begin
    b        = 8'd0;
    crc_en   = 1'b0;
    crc_init = 1'b0;
    adl_en   = 1'b0;
    j        = cmd.idx;
    off      = cmd.idx - 6'd29;
    if (!first_chunk_flag && cmd.idx >= 6'd8) j = cmd.idx + 6'd2;
    case (cmd.sel)
      SEL_HDR: begin
        if (cmd.idx < 6'd8) begin
          b = PNG_SIG[cmd.idx[2:0]];
        end else if (cmd.idx < 6'd12) begin
          b = be_byte(32'd13, cmd.idx[1:0]);
        end else if (cmd.idx < 6'd16) begin
          b = be_byte(TYPE_IHDR, cmd.idx[1:0]);
        end else if (cmd.idx < 6'd20) begin
          b = be_byte({16'd0, lat_width}, cmd.idx[1:0]);
        end else if (cmd.idx < 6'd24) begin
          b = be_byte({1'b0, lat_height}, cmd.idx[1:0]);
        end else if (cmd.idx == 6'd24) begin
          b = 8'd8;
        end else if (cmd.idx == 6'd25) begin
          b = rgb ? 8'd2 : 8'd0;
        end else if (cmd.idx < 6'd29) begin
          b = 8'd0;
        end else begin
          b = be_byte(~chunk_crc, off[1:0]);
        end
        crc_en   = (cmd.idx >= 6'd12) && (cmd.idx < 6'd29);
        crc_init = (cmd.idx == 6'd12);
      end
      SEL_OPEN: begin
        if (j < 6'd4)       b = be_byte(dlen, j[1:0]);
        else if (j < 6'd8)  b = be_byte(TYPE_IDAT, j[1:0]);
        else if (j == 6'd8) b = 8'h78;
        else if (j == 6'd9) b = 8'h01;
        else if (j == 6'd10) b = {7'd0, chunk_last};
        else if (j == 6'd11) b = len[7:0];
        else if (j == 6'd12) b = len[15:8];
        else if (j == 6'd13) b = ~len[7:0];
        else                 b = ~len[15:8];
        crc_en   = (j >= 6'd4);
        crc_init = (j == 6'd4);
      end
      SEL_FILT: begin
        b      = 8'd0;
        crc_en = 1'b1;
        adl_en = 1'b1;
      end
      SEL_SAMP: begin
        b      = samp;
        crc_en = 1'b1;
        adl_en = 1'b1;
      end
      SEL_CRC: begin
        b = be_byte(~chunk_crc, cmd.idx[1:0]);
      end
      SEL_TRAIL: begin
        if (cmd.idx < 6'd4) begin
          b      = be_byte({adler_high_sum, adler_low_sum}, cmd.idx[1:0]);
          crc_en = 1'b1;
        end else if (cmd.idx < 6'd8) begin
          b = be_byte(~chunk_crc, cmd.idx[1:0]);
        end else begin
          off = cmd.idx - 6'd8;
          b   = IEND_BYTES[off[3:0]];
        end
      end
      default: b = 8'd0;
    endcase
  end

  assign crc_src   = crc_init ? 32'hFFFF_FFFF : chunk_crc;
  assign low_sum   = {1'b0, adler_low_sum} + {9'd0, b};
  assign low_next  = (low_sum >= ADLER_MOD) ? low_sum - ADLER_MOD : low_sum;
  assign high_sum  = {1'b0, adler_high_sum} + low_next;
  assign high_next = (high_sum >= ADLER_MOD) ? high_sum - ADLER_MOD : high_sum;

  assign stat.out_free   = !out_valid || out_ready;
  assign stat.div_done   = !div_busy;
  assign stat.rpos_zero  = (row_byte_position == 17'd0);
  assign stat.ric_zero   = (rows_in_chunk == 16'd0);
  assign stat.row_end    = ({1'b0, row_byte_position} + 18'd1) >= {1'b0, row_bytes};
  assign stat.chunk_end  = ({1'b0, rows_in_chunk} + 17'd1) >= {1'b0, chunk_rows};
  assign stat.chunk_last = chunk_last;
  assign stat.first      = first_chunk_flag;

  always_ff @(posedge clk) begin
    if (cmd.take) samp <= sample_byte;
    if (cmd.latch) begin
      lat_width  <= (w_in > maxw) ? maxw : w_in;
      lat_height <= (cfg_height == 31'd0) ? 31'd1 : cfg_height;
      rgb        <= cfg_mode;
    end
    if (cmd.rowb) begin
      row_bytes <= rgb ? 17'(lat_width) + {lat_width, 1'b0} + 17'd1
                       : 17'(lat_width) + 17'd1;
    end
    if (cmd.set_rpc) begin
      rows_per_chunk <= (31'(quotient) > lat_height) ? lat_height[15:0] : quotient;
    end
    if (cmd.open_a) begin
      chunk_rows <= (31'(rows_per_chunk) < left) ? rows_per_chunk : left[15:0];
      chunk_last <= (31'(rows_per_chunk) >= left);
    end
    if (cmd.open_b) len <= len_prod[15:0];
    if (cmd.emit && crc_en) chunk_crc <= crc_byte(crc_src, b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adler_low_sum     <= 16'd1;
      adler_high_sum    <= 16'd0;
      rows_done         <= '0;
      row_byte_position <= '0;
      rows_in_chunk     <= '0;
      first_chunk_flag  <= 1'b1;
    end else if (cmd.latch) begin
      adler_low_sum     <= 16'd1;
      adler_high_sum    <= 16'd0;
      rows_done         <= '0;
      row_byte_position <= '0;
      rows_in_chunk     <= '0;
      first_chunk_flag  <= 1'b1;
    end else begin
      if (cmd.open_done) first_chunk_flag <= 1'b0;
      if (cmd.emit && adl_en) begin
        adler_low_sum  <= low_next[15:0];
        adler_high_sum <= high_next[15:0];
      end
      if (cmd.emit && cmd.sel == SEL_FILT) row_byte_position <= 17'd1;
      if (cmd.emit && cmd.sel == SEL_SAMP) begin
        if (stat.row_end) begin
          row_byte_position <= '0;
          rows_done         <= rows_done + 31'd1;
          rows_in_chunk     <= stat.chunk_end ? 16'd0 : rows_in_chunk + 16'd1;
        end else begin
          row_byte_position <= row_byte_position + 17'd1;
        end
      end
    end
  end

  // Output register: load a new beat when free, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= b;
      run_last <= cmd.last;
      file_end <= cmd.fend;
    end
  end

endmodule

@@ rtl/png_enc_ctrl.sv @@
// Controller: sequences header, chunk framing, row bytes and trailer as samples arrive.
module png_enc_ctrl
  import png_enc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SETUP = 13'b0000000000010,
    S_ROWB  = 13'b0000000000100,
    S_DIVS  = 13'b0000000001000,
    S_DIVW  = 13'b0000000010000,
    S_HDR   = 13'b0000000100000,
    S_OPA   = 13'b0000001000000,
    S_OPB   = 13'b0000010000000,
    S_OPEN  = 13'b0000100000000,
    S_FILT  = 13'b0001000000000,
    S_SAMP  = 13'b0010000000000,
    S_CRC   = 13'b0100000000000,
    S_TRAIL = 13'b1000000000000
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             started, started_next;
  logic             pending, pending_next;
  logic             began, began_next;
  logic             accept;
  logic [IDX_W-1:0] open_len;
  logic             chunk_done;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign open_len   = stat.first ? OPEN_LEN_FIRST : OPEN_LEN;
  assign chunk_done = stat.row_end && stat.chunk_end;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    started_next = started;
    pending_next = pending;
    began_next   = began;
    cmd          = '0;
    cmd.idx      = idx;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.take   = 1'b1;
          began_next = 1'b0;
          idx_next   = '0;
          if (pending)                state_next = S_TRAIL;
          else if (!started)          state_next = S_SETUP;
          else if (!stat.rpos_zero)   state_next = S_SAMP;
          else if (stat.ric_zero)     state_next = S_OPA;
          else                        state_next = S_FILT;
        end
      end
      S_SETUP: begin
        cmd.latch  = 1'b1;
        state_next = S_ROWB;
      end
      S_ROWB: begin
        cmd.rowb   = 1'b1;
        state_next = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.set_rpc = 1'b1;
          idx_next    = '0;
          state_next  = S_HDR;
        end
      end
      S_HDR: begin
        cmd.sel = SEL_HDR;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          idx_next = idx + 1'b1;
          if (idx == HDR_LEN - 1'b1) begin
            started_next = 1'b1;
            began_next   = 1'b1;
            state_next   = S_OPA;
          end
        end
      end
      S_OPA: begin
        cmd.open_a = 1'b1;
        state_next = S_OPB;
      end
      S_OPB: begin
        cmd.open_b = 1'b1;
        idx_next   = '0;
        state_next = S_OPEN;
      end
      S_OPEN: begin
        cmd.sel = SEL_OPEN;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          idx_next = idx + 1'b1;
          if (idx == open_len - 1'b1) begin
            cmd.open_done = 1'b1;
            state_next    = S_FILT;
          end
        end
      end
      S_FILT: begin
        cmd.sel = SEL_FILT;
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_SAMP;
        end
      end
      S_SAMP: begin
        cmd.sel  = SEL_SAMP;
        cmd.last = !chunk_done || (stat.chunk_last && began);
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          idx_next   = '0;
          state_next = S_IDLE;
          if (chunk_done) begin
            if (!stat.chunk_last)  state_next = S_CRC;
            else if (began)        pending_next = 1'b1;
            else                   state_next = S_TRAIL;
          end
        end
      end
      S_CRC: begin
        cmd.sel  = SEL_CRC;
        cmd.last = (idx == CRC_LEN - 1'b1);
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          idx_next = idx + 1'b1;
          if (cmd.last) state_next = S_IDLE;
        end
      end
      S_TRAIL: begin
        cmd.sel  = SEL_TRAIL;
        cmd.last = (idx == TRAIL_LEN - 1'b1);
        cmd.fend = cmd.last;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          idx_next = idx + 1'b1;
          if (cmd.last) begin
            started_next = 1'b0;
            pending_next = 1'b0;
            state_next   = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      started <= 1'b0;
      pending <= 1'b0;
      began   <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      started <= started_next;
      pending <= pending_next;
      began   <= began_next;
    end
  end

endmodule

@@ rtl/png_stored_block_stream_encoder.sv @@
// Top level of the uncompressed PNG stream encoder.
//
//   channel  signals                                    direction
//   in       in_valid, in_ready, sample_byte            sample in, one beat per sample
//   out      out_valid, out_ready, out_byte,            file byte out, one beat per byte
//            run_last, file_end
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  register write, always ready
//
// A sample is accepted in the idle state and then sequenced byte by byte (one
// byte for a mid-row sample, at most 50 bytes); chunk framing adds states OPA
// and OPB, image start adds SETUP, ROWB, DIVS and DIVW, the wait on the
// row-count divider, which yields one quotient bit per cycle. Output stalls
// hold the sequencer; a sample is taken only when the previous one has been
// fully sequenced. Reset returns to idle with the default image setup.
module png_stored_block_stream_encoder
  import png_enc_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  sample_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        file_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  png_enc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  png_enc_dp #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_byte (sample_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .file_end    (file_end)
  );

endmodule
